// ===== design/rtps_pkg.sv =====
// ----------------------------------------------------------------------------
// rtps_pkg
// Shared widths, the queue entry type and a bit-search helper for the
// range-to-prefix splitter.
// ----------------------------------------------------------------------------
package rtps_pkg;

    localparam int ADDRESS_BITS = 32;
    localparam int LEN_W        = $clog2(ADDRESS_BITS + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // One non-empty range waiting for the splitter
    typedef struct packed {
        logic [ADDRESS_BITS-1:0] start;
        logic [ADDRESS_BITS:0]   limit;
    } rtps_range_t;

    // Index of the highest set bit; zero for a zero word
    function automatic logic [LEN_W-1:0] top_bit(input logic [ADDRESS_BITS:0] v);
        logic [LEN_W-1:0] p;
        p = '0;
        for (int i = 0; i <= ADDRESS_BITS; i++) begin
            if (v[i])
                p = LEN_W'(i);
        end
        return p;
    endfunction

endpackage

// ===== design/rtps_front.sv =====
// ----------------------------------------------------------------------------
// rtps_front
// Input side: passes the start address through, saturates the end address to the
// address space, drops empty or inverted ranges and pushes the rest.
// ----------------------------------------------------------------------------
module rtps_front
    import rtps_pkg::*;
(
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [ADDRESS_BITS-1:0] range_start,
    input  logic [ADDRESS_BITS:0]   range_end,
    input  logic                    q_full,
    output logic                    q_push,
    output rtps_range_t             q_data
);

    localparam logic [ADDRESS_BITS:0] SPACE = {1'b1, {ADDRESS_BITS{1'b0}}};

    logic [ADDRESS_BITS:0] limit;
    logic                  empty;

    always_comb
    begin
        limit = (range_end > SPACE) ? SPACE : range_end;
        empty = (limit <= {1'b0, range_start});
    end

    assign in_ready     = !q_full;
    // Empty ranges are taken and dropped here
    assign q_push       = in_valid && !q_full && !empty;
    assign q_data.start = range_start;
    assign q_data.limit = limit;

endmodule

// ===== design/rtps_queue.sv =====
// ----------------------------------------------------------------------------
// rtps_queue
// Small FIFO of pending ranges between the front and the splitter.
// ----------------------------------------------------------------------------
module rtps_queue
    import rtps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rtps_range_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output rtps_range_t pop_data
);

    rtps_range_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== design/rtps_back.sv =====
// ----------------------------------------------------------------------------
// rtps_back
// Splitter: walks one range, emitting one aligned block per cycle into an
// output register when it is free or read. Block size is the smaller of the
// cursor's alignment and the largest power of two that fits in what remains.
// ----------------------------------------------------------------------------
module rtps_back
    import rtps_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  rtps_range_t             q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ADDRESS_BITS-1:0] prefix_address,
    output logic [LEN_W-1:0]        prefix_length,
    output logic                    last_block
);

    logic                    busy_reg, busy_next;
    logic [ADDRESS_BITS-1:0] cursor_reg, cursor_next;
    logic [ADDRESS_BITS:0]   remain_reg, remain_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ADDRESS_BITS-1:0] addr_reg;
    logic [LEN_W-1:0]        len_reg;
    logic                    last_reg;

    logic                    advance;
    logic                    emit;
    logic [ADDRESS_BITS:0]   cur_ext;
    logic [ADDRESS_BITS:0]   low_bit;
    logic [LEN_W-1:0]        align_log2;
    logic [LEN_W-1:0]        fit_log2;
    logic [LEN_W-1:0]        size_log2;
    logic [ADDRESS_BITS:0]   block;
    logic                    is_last;

    assign advance = !out_valid_reg || out_ready;
    assign emit    = busy_reg && advance;
    assign q_pop   = !busy_reg && q_valid;

    always_comb
    begin
        cur_ext    = {1'b0, cursor_reg};
        low_bit    = cur_ext & (~cur_ext + 1'b1);
        // A zero cursor is aligned to the whole space
        align_log2 = (cursor_reg == '0) ? LEN_W'(ADDRESS_BITS) : top_bit(low_bit);
        fit_log2   = top_bit(remain_reg);
        size_log2  = (align_log2 < fit_log2) ? align_log2 : fit_log2;
        block      = {{ADDRESS_BITS{1'b0}}, 1'b1} << size_log2;
        is_last    = (remain_reg == block);
    end

    always_comb
    begin
        busy_next      = busy_reg;
        cursor_next    = cursor_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b0;
        if (q_pop)
        begin
            busy_next   = 1'b1;
            cursor_next = q_data.start;
            remain_next = q_data.limit - {1'b0, q_data.start};
        end
        else if (emit)
        begin
            busy_next      = !is_last;
            cursor_next    = cursor_reg + block[ADDRESS_BITS-1:0];
            remain_next    = remain_reg - block;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        remain_reg <= remain_next;
        if (emit)
        begin
            addr_reg <= cursor_reg;
            len_reg  <= LEN_W'(ADDRESS_BITS) - size_log2;
            last_reg <= is_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign prefix_address = addr_reg;
    assign prefix_length  = len_reg;
    assign last_block     = last_reg;

endmodule

// ===== design/range_to_prefix_split_top.sv =====
// Splits a half-open address range [range_start, range_end) into the minimal
// ascending list of aligned prefix blocks, one result item per block, with
// last_block set on the final one. The splitter emits one block per clock
// while out_ready does not stall the output, and a range holds at most 62
// blocks. It loads the next range from the two-entry input queue only once
// the last block of the current range is emitted. Empty or inverted ranges
// are accepted and dropped with no result and no splitter time. End addresses
// above the address space are saturated to it.
// ----------------------------------------------------------------------------
// range_to_prefix_split_top
// Top level: input classifier, range queue and block splitter.
// ----------------------------------------------------------------------------
module range_to_prefix_split_top
    import rtps_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [ADDRESS_BITS-1:0] range_start,
    input  logic [ADDRESS_BITS:0]   range_end,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ADDRESS_BITS-1:0] prefix_address,
    output logic [LEN_W-1:0]        prefix_length,
    output logic                    last_block
);

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    rtps_range_t q_in;
    rtps_range_t q_out;

    rtps_front u_front
    (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .range_start (range_start),
        .range_end   (range_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    rtps_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    rtps_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_data         (q_out),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .prefix_address (prefix_address),
        .prefix_length  (prefix_length),
        .last_block     (last_block)
    );

endmodule

// ===== design/rtps_checker.sv =====
// ----------------------------------------------------------------------------
// rtps_checker
// Port-level checks on the splitter's result stream.
// ----------------------------------------------------------------------------
module rtps_checker
    import rtps_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [ADDRESS_BITS-1:0] prefix_address,
    input logic [LEN_W-1:0]        prefix_length,
    input logic                    last_block
);

    logic [ADDRESS_BITS:0] low_mask;

    assign low_mask = ({{ADDRESS_BITS{1'b0}}, 1'b1} << (LEN_W'(ADDRESS_BITS) - prefix_length))
                      - 1'b1;

    // Hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(prefix_address)
            && $stable(prefix_length) && $stable(last_block))
        else $error("result item changed while stalled");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> prefix_length <= LEN_W'(ADDRESS_BITS))
        else $error("prefix length beyond address width");

    // Every block starts on its own size boundary
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, prefix_address} & low_mask) == '0)
        else $error("block address not aligned to its size");

    // A whole-space block is the only block of its range
    a_full_space: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && prefix_length == '0 |-> last_block && prefix_address == '0)
        else $error("whole-space block not alone");

endmodule

bind range_to_prefix_split_top rtps_checker u_rtps_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .prefix_address (prefix_address),
    .prefix_length  (prefix_length),
    .last_block     (last_block)
);
